// ===== rtl/core/stm_pkg.sv =====
// ---------------------------------------------------------------------------
// stm_pkg
// Shared types and constants for the silence trimmer with lead/tail margins.
// ---------------------------------------------------------------------------
package stm_pkg;

  localparam int REPEAT_BITS   = 20;
  localparam int DEF_RUN_BITS  = 20;
  localparam int SAMPLE_BITS   = 8;
  localparam int MARGIN_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [SAMPLE_BITS-1:0] SILENCE_RESET = 8'h80;
  localparam logic [MARGIN_BITS-1:0] LEAD_RESET    = 16'd220;
  localparam logic [MARGIN_BITS-1:0] TAIL_RESET    = 16'd1200;

  localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEAD    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAIL    = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [REPEAT_BITS-1:0] rep;
    logic                   last;
  } res_t;

  // up to two results pushed per request, first slot first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== rtl/core/silence_trimmer_with_margins.sv =====
// ---------------------------------------------------------------------------
// silence_trimmer_with_margins
// Trims leading/trailing silence of an 8-bit PCM utterance, keeping margins;
// run-length coded output.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one sample per request, with
// final_sample on the last sample of an utterance. Output channel
// out_valid/out_ready carries (value, repeat_res, end_of_run) results.
// A silent sample yields nothing unless final; a sound sample yields an
// optional held silent run followed by itself, so one request gives 0..2
// results. Results pass through the registered result queue to the output.
// Throughput: one sample per cycle while each yields at most one result and
// the receiver keeps up; the three-entry result queue drops in_ready whenever
// it holds two or more results, so a request giving two results holds off
// the next request until one is taken. A stalled receiver fills the queue
// and then holds in_ready low; nothing is lost. Reset (rst, synchronous)
// empties the queue, clears the run state and loads register defaults (silence
// 0x80, lead 220, tail 1200). Config index 3 is ignored. The user must write
// registers with cfg_we/cfg_index/cfg_data only while idle (not enforced).
// ---------------------------------------------------------------------------
module silence_trimmer_with_margins #(
  parameter int RUN_BITS = stm_pkg::DEF_RUN_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic                                final_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [stm_pkg::SAMPLE_BITS-1:0]     value,
  output logic [stm_pkg::REPEAT_BITS-1:0]     repeat_res,
  output logic                                end_of_run,
  input  logic                                cfg_we,
  input  logic [stm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import stm_pkg::*;

  logic [SAMPLE_BITS-1:0] silence_value;
  logic [MARGIN_BITS-1:0] lead_margin;
  logic [MARGIN_BITS-1:0] tail_margin;
  logic                   acc;
  push_t                  push;
  res_t                   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_value <= SILENCE_RESET;
      lead_margin   <= LEAD_RESET;
      tail_margin   <= TAIL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SILENCE: silence_value <= cfg_data[SAMPLE_BITS-1:0];
        REG_LEAD:    lead_margin   <= cfg_data[MARGIN_BITS-1:0];
        REG_TAIL:    tail_margin   <= cfg_data[MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign acc = in_valid & in_ready;

  stm_core #(.RUN_BITS(RUN_BITS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .acc           (acc),
    .sample        (sample),
    .final_sample  (final_sample),
    .silence_value (silence_value),
    .lead_margin   (lead_margin),
    .tail_margin   (tail_margin),
    .push          (push)
  );

  stm_rq u_rq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign value      = head.value;
  assign repeat_res = head.rep;
  assign end_of_run = head.last;

endmodule

// ===== rtl/core/stm_core.sv =====
// ---------------------------------------------------------------------------
// stm_core
// Silence detection, held silent run counter and result generation.
// ---------------------------------------------------------------------------
module stm_core #(
  parameter int RUN_BITS = stm_pkg::DEF_RUN_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 acc,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]      sample,
  input  logic                                 final_sample,
  input  logic [stm_pkg::SAMPLE_BITS-1:0]      silence_value,
  input  logic [stm_pkg::MARGIN_BITS-1:0]      lead_margin,
  input  logic [stm_pkg::MARGIN_BITS-1:0]      tail_margin,
  output stm_pkg::push_t                       push
);
  import stm_pkg::*;

  localparam int CW = (RUN_BITS > REPEAT_BITS) ? RUN_BITS : REPEAT_BITS;
  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
  localparam logic [CW-1:0] REP_MAX = CW'({REPEAT_BITS{1'b1}});

  function automatic logic [REPEAT_BITS-1:0] sat(input logic [CW-1:0] c);
    logic [REPEAT_BITS-1:0] r;
    r = (c > REP_MAX) ? REP_MAX[REPEAT_BITS-1:0] : c[REPEAT_BITS-1:0];
    return r;
  endfunction

  logic                heard, heard_next;
  logic [RUN_BITS-1:0] run, run_next, run_inc;
  logic                is_sil;
  logic [CW-1:0]       run_w, inc_w, lead_w, tail_w, lead_c, tail_c, sil_c, fin_c;

  assign is_sil  = (sample == silence_value);
  assign run_inc = (run == RUN_MAX) ? run : run + 1'b1;
  assign run_w   = CW'(run);
  assign inc_w   = CW'(run_inc);
  assign lead_w  = CW'(lead_margin);
  assign tail_w  = CW'(tail_margin);
  assign lead_c  = (run_w < lead_w) ? run_w : lead_w;
  assign tail_c  = (inc_w < tail_w) ? inc_w : tail_w;
  assign sil_c   = heard ? run_w : lead_c;
  assign fin_c   = heard ? tail_c : '0;

  always_comb begin
    push.v0       = acc & (is_sil ? final_sample : (sil_c != '0));
    push.r0.value = silence_value;
    push.r0.rep   = is_sil ? sat(fin_c) : sat(sil_c);
    push.r0.last  = is_sil;
    push.v1       = acc & ~is_sil;
    push.r1.value = sample;
    push.r1.rep   = REPEAT_BITS'(1);
    push.r1.last  = final_sample;
  end

  always_comb begin
    heard_next = heard;
    run_next   = run;
    if (acc) begin
      if (final_sample) begin
        heard_next = 1'b0;
        run_next   = '0;
      end else if (is_sil) begin
        run_next = run_inc;
      end else begin
        heard_next = 1'b1;
        run_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heard <= 1'b0;
      run   <= '0;
    end else begin
      heard <= heard_next;
      run   <= run_next;
    end
  end

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    acc && final_sample |=> !heard && run == '0)
    else $error("state not cleared after final sample");
  a_sound_sets: assert property (@(posedge clk) disable iff (rst)
    acc && !is_sil && !final_sample |=> heard && run == '0)
    else $error("sound did not set heard flag");
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    !acc |=> $stable(run) && $stable(heard))
    else $error("state changed without request");
`endif

endmodule

// ===== rtl/core/stm_rq.sv =====
// ---------------------------------------------------------------------------
// stm_rq
// Three-entry result queue; takes up to two results per cycle, gives one.
// ---------------------------------------------------------------------------
module stm_rq (
  input  logic                             clk,
  input  logic                             rst,
  input  stm_pkg::push_t                   push,
  output logic                             space,
  output logic                             out_valid,
  input  logic                             out_ready,
  output stm_pkg::res_t                    head
);
  import stm_pkg::*;

  localparam int DEPTH = 3;

  res_t       q [DEPTH];
  res_t       q_next [DEPTH];
  logic [1:0] cnt, cnt_next, cnt_pop, cnt_mid;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid & out_ready;
  assign space     = (cnt <= 2'd1);
  assign head      = q[0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
    end
    cnt_pop = cnt;
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
      cnt_pop = cnt - 2'd1;
    end
    cnt_mid = cnt_pop + {1'b0, push.v0};
    for (int i = 0; i < DEPTH; i++) begin
      if (push.v0 && cnt_pop == 2'(i)) q_next[i] = push.r0;
      if (push.v1 && cnt_mid == 2'(i)) q_next[i] = push.r1;
    end
    cnt_next = cnt_mid + {1'b0, push.v1};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.v0 || push.v1) |-> cnt <= 2'd1)
    else $error("push into full queue");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 && !(push.v0 || push.v1) |=> cnt == 2'd0)
    else $error("queue filled without push");
  a_zero_rep_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && q[0].rep == '0 |-> q[0].last)
    else $error("empty result not marked last");
`endif

endmodule
